### hdl/cci_pkg.sv
// Shared types and fixed widths for the commodity channel index block.
// No dependencies; imported by cci_div, commodity_channel_index_top and the testbench.
package cci_pkg;

    // typical-price sum high + low + close of three 32-bit prices
    localparam int TS_W = 34;
    // period register width and its reset value
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 7'd20;

    // index magnitude stays below 200 * 127 / 3 < 2**14, plus 16 fraction bits
    localparam int QI_W = 14;
    localparam int QF_W = 16;
    localparam int QB_W = QI_W + QF_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_WALK,
        ST_DRAIN,
        ST_NUM,
        ST_SCALE,
        ST_DIVGO,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

### hdl/cci_div.sv
// Serial restoring divider: one quotient bit per cycle, then round half up.
// Gives round(dividend * 2**QF_W / divisor); depends on cci_pkg.
module cci_div #(
    parameter int A_W = 63,
    parameter int B_W = 50
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [A_W-1:0]              dividend,
    input  logic [B_W-1:0]              divisor,
    output logic                        done,
    output logic [cci_pkg::QB_W:0]      quotient
);
    import cci_pkg::*;

    localparam int CNT_W = $clog2(QB_W + 1);

    logic             run_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [B_W-1:0]   rem_reg;
    logic [B_W-1:0]   dsr_reg;
    logic [QB_W-1:0]  dvd_reg;
    logic [QB_W-1:0]  q_reg;
    logic [QB_W:0]    quotient_reg;

    logic [B_W:0]     trial;
    logic             take;
    logic             round_up;

    assign trial    = {rem_reg, dvd_reg[QB_W-1]};
    assign take     = trial >= {1'b0, dsr_reg};
    assign round_up = {rem_reg, 1'b0} >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(QB_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // integer part of the quotient fits QI_W bits, so the high part is below divisor
            rem_reg <= B_W'(dividend >> QI_W);
            dsr_reg <= divisor;
            dvd_reg <= {dividend[QI_W-1:0], {QF_W{1'b0}}};
            q_reg   <= '0;
        end else if (run_reg) begin
            rem_reg <= take ? B_W'(trial - {1'b0, dsr_reg}) : B_W'(trial);
            dvd_reg <= dvd_reg << 1;
            q_reg   <= {q_reg[QB_W-2:0], take};
        end
        if (fin_reg) begin
            quotient_reg <= {1'b0, q_reg} + (QB_W+1)'(round_up);
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

### hdl/commodity_channel_index_top.sv
// Commodity channel index: one bar in, one index word out per bar; uses cci_pkg and cci_div.
// A filling window emits straight after the ring update; a full window walks the deviation sum on
// the ring's single read port, and a non-flat window then runs the serial divide before emitting.
// A new bar is accepted only once the previous word has moved to the output register, and a
// stalled output register holds the datapath.
// Reset: period 20, window empty; the ring memory is not cleared (only written slots are used).
module commodity_channel_index_top #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [cci_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [31:0]                s_bar_high,
    input  logic [31:0]                s_bar_low,
    input  logic [31:0]                s_bar_close,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_cci_value,
    output logic                       m_window_full,
    output logic                       m_flat_window
);
    import cci_pkg::*;

    localparam int PW     = ($clog2(WINDOW_DEPTH + 1) < CFG_W) ?
                            $clog2(WINDOW_DEPTH + 1) : CFG_W;
    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = TS_W + PW;
    localparam int DEV_W  = SUM_W + PW;
    localparam int B_W    = DEV_W + 2;
    localparam int NP_W   = SUM_W + PW;
    localparam int A_W    = NP_W + 8;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] period_reg;
    logic [CFG_W-1:0] p_clamp;
    logic [PW-1:0]    p_eff;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    bars_reg;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    walk_cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [TS_W-1:0]  s_reg;
    logic [SUM_W-1:0] sp_reg;
    logic [SUM_W-1:0] prod_reg;
    logic [DEV_W-1:0] acc_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             neg_reg;
    logic [SUM_W-1:0] nmag_reg;
    logic [B_W-1:0]   b_reg;
    logic [NP_W-1:0]  np_reg;

    logic signed [31:0] res_value_reg;
    logic               res_full_reg;
    logic               res_flat_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_value_reg;
    logic               m_full_reg;
    logic               m_flat_reg;

    // ring memory, one write and one registered read port
    logic [TS_W-1:0]  ring_mem [WINDOW_DEPTH];
    logic [TS_W-1:0]  rd_data_reg;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;

    logic             s_fire;
    logic             out_free;
    logic             full_old;
    logic             full_new;
    logic [AW:0]      back_tmp;
    logic [AW-1:0]    oldest_addr;
    logic [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0] dev_term;
    logic [A_W-1:0]   dividend;
    logic             div_start;
    logic             div_done;
    logic [QB_W:0]    div_q;
    logic [31:0]      q32;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // clamp the period to 2..WINDOW_DEPTH
    always_comb begin
        if (period_reg < CFG_W'(2)) begin
            p_clamp = CFG_W'(2);
        end else if (32'(period_reg) > 32'(WINDOW_DEPTH)) begin
            p_clamp = CFG_W'(WINDOW_DEPTH);
        end else begin
            p_clamp = period_reg;
        end
    end
    assign p_eff = PW'(p_clamp);

    assign full_old = bars_reg >= p_reg;
    assign full_new = full_old || ((bars_reg + 1'b1) == p_reg);

    // slot that drops out of the window: wp - P modulo depth
    assign back_tmp    = {1'b0, wp_reg} + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(p_reg);
    assign oldest_addr = (back_tmp >= (AW+1)'(WINDOW_DEPTH)) ?
                         AW'(back_tmp - (AW+1)'(WINDOW_DEPTH)) : AW'(back_tmp);

    assign sum_new  = sum_reg - (full_old ? SUM_W'(rd_data_reg) : '0) + SUM_W'(s_reg);
    assign dev_term = (prod_reg >= sum_reg) ? prod_reg - sum_reg : sum_reg - prod_reg;

    // N * P * 200 as three shifted terms
    assign dividend = (A_W'(np_reg) << 7) + (A_W'(np_reg) << 6) + (A_W'(np_reg) << 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = rd_ptr_reg;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                mem_re     = 1'b1;
                mem_raddr  = oldest_addr;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                mem_we     = 1'b1;
                state_next = full_new ? ST_WALK : ST_EMIT;
            end
            ST_WALK: begin
                mem_re = 1'b1;
                if (walk_cnt_reg == PW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                state_next = (acc_reg == '0) ? ST_EMIT : ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wp_reg] <= s_reg;
        end
        if (mem_re) begin
            rd_data_reg <= ring_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RESET;
            bars_reg    <= '0;
            sum_reg     <= '0;
            wp_reg      <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_WALK);
            v2_reg <= v1_reg;
            if (cfg_wr_en) begin
                // restart the window
                period_reg <= cfg_wr_data;
                bars_reg   <= '0;
                sum_reg    <= '0;
            end else if (state_reg == ST_UPDATE) begin
                sum_reg <= sum_new;
                if (!full_old) begin
                    bars_reg <= bars_reg + 1'b1;
                end
            end
            if (state_reg == ST_UPDATE) begin
                wp_reg <= (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s_reg <= TS_W'(s_bar_high) + TS_W'(s_bar_low) + TS_W'(s_bar_close);
            p_reg <= p_eff;
        end
        if (state_reg == ST_UPDATE) begin
            sp_reg        <= SUM_W'(s_reg) * SUM_W'(p_reg);
            rd_ptr_reg    <= wp_reg;
            walk_cnt_reg  <= p_reg;
            acc_reg       <= '0;
            res_value_reg <= '0;
            res_full_reg  <= 1'b0;
            res_flat_reg  <= 1'b0;
        end
        if (state_reg == ST_WALK) begin
            rd_ptr_reg   <= (rd_ptr_reg == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_reg - 1'b1;
            walk_cnt_reg <= walk_cnt_reg - 1'b1;
        end
        if (v1_reg) begin
            prod_reg <= SUM_W'(rd_data_reg) * SUM_W'(p_reg);
        end
        if (v2_reg) begin
            acc_reg <= acc_reg + DEV_W'(dev_term);
        end
        if (state_reg == ST_NUM) begin
            neg_reg      <= sp_reg < sum_reg;
            nmag_reg     <= (sp_reg >= sum_reg) ? sp_reg - sum_reg : sum_reg - sp_reg;
            b_reg        <= B_W'(acc_reg) + (B_W'(acc_reg) << 1);
            res_full_reg <= 1'b1;
            res_flat_reg <= (acc_reg == '0);
        end
        if (state_reg == ST_SCALE) begin
            np_reg <= NP_W'(nmag_reg) * NP_W'(p_reg);
        end
        if (state_reg == ST_DIV && div_done) begin
            res_value_reg <= neg_reg ? -$signed(q32) : $signed(q32);
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_value_reg <= res_value_reg;
            m_full_reg  <= res_full_reg;
            m_flat_reg  <= res_flat_reg;
        end
    end

    // the quotient stays below 2**31 since |N| <= D, so no clip is needed
    assign q32 = 32'(div_q);

    cci_div #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid       = m_valid_reg;
    assign m_cci_value   = m_value_reg;
    assign m_window_full = m_full_reg;
    assign m_flat_window = m_flat_reg;

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_walk_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NUM |-> !v1_reg && !v2_reg)
        else $error("deviation sum used before the walk pipeline drained");

    a_bars_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> bars_reg <= p_reg)
        else $error("bar count above the period");

    a_flat_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_flat_reg || !m_full_reg) |-> m_value_reg == 32'sd0)
        else $error("nonzero index on a flat or filling word");

endmodule

### sim/testbench.sv
// Self-checking bench for commodity_channel_index_top: directed and random bars against a built-in CCI model.
// Depends on cci_pkg and commodity_channel_index_top; needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cci_pkg::*;

    localparam int WINDOW_DEPTH = 64;
    localparam int BAR_TARGET = 1800;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 300;
    localparam int QUIET_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic             is_cfg;
        logic [CFG_W-1:0] period;
        logic [31:0]      high;
        logic [31:0]      low;
        logic [31:0]      close;
    } bar_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               full;
        logic               flat;
    } cci_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [31:0]        s_bar_high = '0;
    logic [31:0]        s_bar_low = '0;
    logic [31:0]        s_bar_close = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_cci_value;
    logic               m_window_full;
    logic               m_flat_window;

    always #2 aclk = ~aclk;

    commodity_channel_index_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_bar_high(s_bar_high),
        .s_bar_low(s_bar_low),
        .s_bar_close(s_bar_close),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_cci_value(m_cci_value),
        .m_window_full(m_window_full),
        .m_flat_window(m_flat_window)
    );

    // model state
    logic [TS_W-1:0]  tp_ring [WINDOW_DEPTH];
    int unsigned      ring_ptr = 0;
    int unsigned      bars_in = 0;
    logic [63:0]      tp_sum = '0;
    logic [CFG_W-1:0] period_reg = PERIOD_RESET;

    bar_word_t   bar_queue[$];
    cci_word_t   cci_expected[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // random bar generator state
    logic [31:0] price_base = 32'h0064_0000;
    logic [31:0] prev_high = '0;
    logic [31:0] prev_low = '0;
    logic [31:0] prev_close = '0;
    int unsigned repeat_left = 0;

    function automatic int unsigned clamp_period(logic [CFG_W-1:0] v);
        int unsigned p;
        p = v;
        if (p < 2) p = 2;
        if (p > WINDOW_DEPTH) p = WINDOW_DEPTH;
        return p;
    endfunction

    // Slide the window by one bar and work out the index word it produces.
    function automatic cci_word_t next_cci(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl);
        cci_word_t    w;
        int unsigned  p;
        int unsigned  k;
        logic [63:0]  s;
        logic [63:0]  scaled_tp;
        logic [63:0]  dev_sum;
        logic [63:0]  num_mag;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [127:0] q;
        logic [127:0] r;
        bit           neg;
        p = clamp_period(period_reg);
        s = 64'(hi) + 64'(lo) + 64'(cl);
        if (bars_in >= p)
            tp_sum -= 64'(tp_ring[(ring_ptr + WINDOW_DEPTH - p) % WINDOW_DEPTH]);
        tp_ring[ring_ptr] = s[TS_W-1:0];
        tp_sum += s;
        if (bars_in < p) bars_in++;
        w = '0;
        if (bars_in >= p) begin
            w.full = 1'b1;
            dev_sum = '0;
            for (k = 0; k < p; k++) begin
                scaled_tp = 64'(tp_ring[(ring_ptr + WINDOW_DEPTH - k) % WINDOW_DEPTH]) * 64'(p);
                dev_sum += (scaled_tp >= tp_sum) ? scaled_tp - tp_sum : tp_sum - scaled_tp;
            end
            if (dev_sum == 0) begin
                w.flat = 1'b1;
            end else begin
                scaled_tp = s * 64'(p);
                neg = scaled_tp < tp_sum;
                num_mag = neg ? tp_sum - scaled_tp : scaled_tp - tp_sum;
                a = num_mag * 64'(p) * 64'd200;
                b = dev_sum * 64'd3;
                q = (128'(a) << 16) / 128'(b);
                r = (128'(a) << 16) % 128'(b);
                // round half away from zero, then saturate
                if (r >= 128'(b) - r) q++;
                if (neg) begin
                    if (q > 128'h8000_0000) q = 128'h8000_0000;
                    w.value = -q[31:0];
                end else begin
                    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
                    w.value = q[31:0];
                end
            end
        end
        ring_ptr = (ring_ptr + 1) % WINDOW_DEPTH;
        return w;
    endfunction

    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic void push_bar(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl);
        bar_word_t w;
        w = '0;
        w.high = hi;
        w.low = lo;
        w.close = cl;
        bar_queue = {bar_queue, w};
    endfunction

    function automatic void push_period(logic [CFG_W-1:0] v);
        bar_word_t w;
        w = '0;
        w.is_cfg = 1'b1;
        w.period = v;
        bar_queue = {bar_queue, w};
    endfunction

    // Mostly a drifting price series; some fully random bars and some repeated runs
    // long enough to flatten short windows.
    function automatic void push_random_bar();
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] cl;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (repeat_left > 0 || pick < 5) begin
            if (repeat_left == 0) repeat_left = $urandom_range(2, 24);
            repeat_left--;
            hi = prev_high;
            lo = prev_low;
            cl = prev_close;
        end else if (pick < 20) begin
            hi = $urandom();
            lo = $urandom();
            cl = $urandom();
        end else begin
            if (pick < 23) price_base = $urandom();
            else price_base = price_base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            hi = price_base + $urandom_range(0, 32'h0003_0000);
            lo = price_base - $urandom_range(0, 32'h0003_0000);
            cl = lo + $urandom_range(0, hi - lo);
        end
        prev_high = hi;
        prev_low = lo;
        prev_close = cl;
        push_bar(hi, lo, cl);
    endfunction

    // Driver: bars and period writes from bar_queue; writes only once the block has drained.
    int unsigned tx_wait = 0;
    int unsigned tx_calm = 0;
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        logic      nxt_valid;
        logic      nxt_cfg;
        bar_word_t tx_word;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_cfg = 1'b0;
            if (s_valid && s_ready) begin
                cci_expected = {cci_expected, next_cci(s_bar_high, s_bar_low, s_bar_close)};
                nxt_valid = 1'b0;
            end
            quiet_cycles = (cci_expected.size() == 0 && !nxt_valid) ? quiet_cycles + 1 : 0;
            if (!nxt_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (bar_queue.size() > 0) begin
                    if (!bar_queue[0].is_cfg) begin
                        tx_word = bar_queue.pop_front();
                        s_bar_high <= tx_word.high;
                        s_bar_low <= tx_word.low;
                        s_bar_close <= tx_word.close;
                        nxt_valid = 1'b1;
                        tx_wait = draw_wait(tx_calm);
                    end else if (quiet_cycles >= QUIET_CYCLES) begin
                        tx_word = bar_queue.pop_front();
                        cfg_wr_data <= tx_word.period;
                        nxt_cfg = 1'b1;
                        // a period write restarts the window
                        period_reg = tx_word.period;
                        bars_in = 0;
                        tp_sum = '0;
                        tx_wait = draw_wait(tx_calm);
                    end
                end
            end
            s_valid <= nxt_valid;
            cfg_wr_en <= nxt_cfg;
        end
    end

    // Monitor: check each result word against the oldest expectation.
    int unsigned rx_wait = 0;
    int unsigned rx_calm = 0;

    always @(posedge aclk) begin
        cci_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cci_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result word: value %0d full %0b flat %0b",
                                 m_cci_value, m_window_full, m_flat_window);
                end else begin
                    want = cci_expected.pop_front();
                    if (want.value !== m_cci_value || want.full !== m_window_full ||
                        want.flat !== m_flat_window) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     want.value, want.full, want.flat,
                                     m_cci_value, m_window_full, m_flat_window);
                    end
                end
                rx_wait = draw_wait(rx_calm);
            end
            // count the stall down only while a word is offered
            if (rx_wait > 0) begin
                if (m_valid) rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** commodity_channel_index_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned      bar_total;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      pick;
        logic [CFG_W-1:0] per;
        bar_total = 0;
        phase = 0;

        // reset period still filling after three bars
        push_bar(32'h0, 32'h0, 32'h0);
        push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_bar(32'h0001_0000, 32'h0000_FFFF, 32'h0001_8000);
        // shortest window: flat at the top, swings to both extremes
        push_period(7'd2);
        push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_bar(32'h0, 32'h0, 32'h0);
        push_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_bar(32'h0, 32'h0, 32'h0);
        push_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        push_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
        // zero period acts as two; then a flat window of zeros
        push_period(7'd0);
        push_bar(32'h1, 32'h0, 32'h0);
        push_bar(32'h0, 32'h0, 32'h0);
        push_bar(32'h0, 32'h0, 32'h0);
        push_period(7'd3);
        push_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_bar(32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        push_bar(32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
        push_bar(32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
        push_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

        while (bar_total < BAR_TARGET) begin
            case (phase)
                0: per = 7'd64;
                1: per = 7'd127;
                2: per = 7'd1;
                3: per = 7'd65;
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7) per = $urandom_range(2, 12);
                    else if (pick < 9) per = $urandom_range(13, 40);
                    else per = $urandom_range(0, 127);
                end
            endcase
            push_period(per);
            n = clamp_period(per) + $urandom_range(3, 50);
            repeat (n) push_random_bar();
            bar_total += n;
            phase++;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (bar_queue.size() != 0 || s_valid || cci_expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("** commodity_channel_index_top: PASSED **");
        end else begin
            $display("** commodity_channel_index_top: FAILED **");
        end
        $finish;
    end

endmodule
